// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk; only ASSERT_CLK is disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mcmm_pkg.sv
// ----------------------------------------------------------------------------
// mcmm_pkg
// Types and constants for the multi-channel moving median.
// ----------------------------------------------------------------------------
package mcmm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int WIN_LEN_W     = 4;
  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 4'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // handoff between neighboring sort cells
  typedef struct packed {
    logic    valid;
    logic    lt;
    sample_t val;
  } cell_link_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SORT = 3'b010,
    S_PUSH = 3'b100
  } state_t;

endpackage

// File: src/multi_channel_moving_median.sv
// ----------------------------------------------------------------------------
// multi_channel_moving_median
// Moving median per channel over the most recent window_len samples.
// ----------------------------------------------------------------------------
// Each word passes these steps from acceptance to result, where n is window_len
// held within 1..WINDOW_SLOTS-1: the sample is stored, the channel's window is
// fed one slot per cycle, n slots in all, into a row of insertion sort cells,
// and the output register is loaded. The next word is taken as
// soon as the result sits in the output register. A channel number of
// CHANNELS or more changes no channel's window and yields a median of 0.
`include "assert_macros.svh"

module multi_channel_moving_median
  import mcmm_pkg::*;
#(
  parameter int CHANNELS     = 2,
  parameter int WINDOW_SLOTS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [WIN_LEN_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 channel,
  input  sample_t              sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sample_t              median
);

  localparam int SW    = $clog2(WINDOW_SLOTS);
  localparam int NCELL = WINDOW_SLOTS - 1;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [WIN_LEN_W-1:0] window_len;
  logic [SW-1:0]        ptr [CHANNELS];
  sample_t              store [CHANNELS][WINDOW_SLOTS];
  state_t               state;
  logic [CW-1:0]        ch_r;
  logic [SW-1:0]        n_r;
  logic [SW-1:0]        idx;
  logic                 bad_r;

  logic [SW-1:0] n_eff;
  logic [CW-1:0] ch_in;
  logic          ch_ok;
  logic [SW:0]   p_inc;
  logic [SW-1:0] p_next;
  logic          in_fire;
  logic          sort_on;
  sample_t       x;
  sample_t       sel;
  cell_link_t    link [NCELL+1];

  always_comb begin
    if (window_len == '0) begin
      n_eff = SW'(1);
    end else if (int'(window_len) > WINDOW_SLOTS - 1) begin
      n_eff = SW'(WINDOW_SLOTS - 1);
    end else begin
      n_eff = SW'(window_len);
    end
  end

  assign ch_in   = CW'(channel);
  assign ch_ok   = int'(channel) < CHANNELS;
  assign p_inc   = {1'b0, ptr[ch_in]} + (SW+1)'(1);
  assign p_next  = (p_inc >= {1'b0, n_eff}) ? '0 : p_inc[SW-1:0];
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign sort_on  = (state == S_SORT);
  assign x        = store[ch_r][idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      window_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ptr[c] <= '0;
        for (int s = 0; s < WINDOW_SLOTS; s++) begin
          store[c][s] <= '0;
        end
      end
    end else if (in_fire && ch_ok) begin
      ptr[ch_in]           <= p_next;
      store[ch_in][p_next] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_PUSH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= ch_ok ? S_SORT : S_PUSH;
          end
        end
        S_SORT: begin
          if (idx == n_r - SW'(1)) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r  <= ch_in;
      n_r   <= n_eff;
      bad_r <= !ch_ok;
      idx   <= '0;
    end else if (sort_on) begin
      idx <= idx + SW'(1);
    end
  end

  always_comb begin
    sel = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (int'(n_r >> 1) == k) begin
        sel = link[k+1].val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && (!out_valid || out_ready)) begin
      median <= bad_r ? sample_t'(0) : sel;
    end
  end

  assign link[0] = '{valid: 1'b1, lt: 1'b0, val: '0};

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    mcmm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (in_fire),
      .insert   (sort_on),
      .x        (x),
      .link_in  (link[k]),
      .link_out (link[k+1])
    );
  end

  `ASSERT_CLK(a_ptr_in_window, in_fire && ch_ok |=> ptr[ch_r] < n_r, "pointer outside window")
  `ASSERT_CLK(a_sort_ends, sort_on && idx == n_r - SW'(1) |=> state == S_PUSH, "sort overran")
  `ASSERT_CLK(a_idx_bound, sort_on |-> idx < n_r, "window index past length")
  `ASSERT_ALWAYS(a_ready_idle, in_ready |-> state == S_IDLE, "ready while busy")

endmodule

// File: src/mcmm_cell.sv
// ----------------------------------------------------------------------------
// mcmm_cell
// One slot of the insertion sort row: hold a value, take the broadcast word
// or the left neighbor's value when the word ranks at or before this slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcmm_cell
  import mcmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       insert,
  input  sample_t    x,
  input  cell_link_t link_in,
  output cell_link_t link_out
);

  logic    valid;
  sample_t val;
  logic    lt;

  assign lt = !valid || (x < val);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (insert && lt && link_in.valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (insert && lt && link_in.valid) begin
      val <= link_in.lt ? link_in.val : x;
    end
  end

  assign link_out.valid = valid;
  assign link_out.lt    = lt;
  assign link_out.val   = val;

  `ASSERT_ALWAYS(a_fill_contiguous, link_out.valid |-> link_in.valid, "cell filled out of order")
  `ASSERT_CLK(a_rank_monotone, link_in.lt |-> lt, "sort row out of order")

endmodule
